// File: rtl/assert_macros.svh
// Assertion macros shared by the line receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LRT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define LRT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: rtl/lrt_pkg.sv
// Types and constants shared by the line receiver modules.
package lrt_pkg;

	localparam logic [7:0] LF_CHAR = 8'h0A;
	localparam logic [7:0] CR_CHAR = 8'h0D;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_CHARS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT   = 1'b1;

	localparam logic [3:0]  MAX_CHARS_RST = 4'd14;
	localparam logic [15:0] TIMEOUT_RST   = 16'd13100;

	// Wide enough for a line length of the largest supported store.
	localparam int LEN_W = 9;

	typedef enum logic [1:0] {
		REASON_NEWLINE  = 2'd0,
		REASON_TIMEOUT  = 2'd1,
		REASON_OVERFLOW = 2'd2
	} reason_t;

	// One finished line handed from the front to the back.
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		reason_t          reason;
		logic             empty;
	} desc_t;

endpackage

// File: rtl/lrt_ram.sv
// Generic single write port RAM with a registered read port.
module lrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/lrt_front.sv
// Front end: takes bytes and ticks, fills the line store, detects line ends.
`include "assert_macros.svh"
module lrt_front #(
	parameter int STORE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	input  logic                           s_tuser,
	input  logic                           cfg_we,
	input  logic [lrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output logic                           push,
	output lrt_pkg::desc_t                 push_desc,
	input  logic                           line_done,
	output logic                           ram_we,
	output logic [$clog2(STORE_DEPTH):0]   ram_waddr,
	output logic [7:0]                     ram_wdata
);
	import lrt_pkg::*;

	localparam int CW   = $clog2(STORE_DEPTH + 1);
	localparam int AW   = $clog2(STORE_DEPTH);
	localparam int CMPW = (CW > 4) ? CW : 4;

	logic [3:0]    max_chars_q;
	logic [15:0]   timeout_q;
	logic [CW-1:0] count_q, count_d, cnt_nx;
	logic          run_q, run_d;
	logic [15:0]   idle_q, idle_d, idle_nx;
	logic          bank_q, bank_d;
	logic [1:0]    outst_q;
	logic          acc, is_term, ovf, tmo, finish;

	assign s_tready = (outst_q != 2'd2);
	assign acc      = s_tvalid && s_tready;
	assign is_term  = (s_tdata == LF_CHAR) || (s_tdata == CR_CHAR);
	assign cnt_nx   = count_q + CW'(1);
	assign ovf      = (CMPW'(cnt_nx) >= CMPW'(max_chars_q)) || (cnt_nx == CW'(STORE_DEPTH));
	assign idle_nx  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign tmo      = (idle_nx >= timeout_q);

	assign ram_waddr = {bank_q, count_q[AW-1:0]};
	assign ram_wdata = s_tdata;

	always_comb begin
		push             = 1'b0;
		finish           = 1'b0;
		push_desc.bank   = bank_q;
		push_desc.len    = LEN_W'(count_q);
		push_desc.reason = REASON_NEWLINE;
		push_desc.empty  = 1'b0;
		ram_we           = 1'b0;
		count_d          = count_q;
		run_d            = run_q;
		idle_d           = idle_q;
		if (acc) begin
			if (s_tuser == OP_BYTE) begin
				if (is_term) begin
					push            = 1'b1;
					finish          = 1'b1;
					push_desc.empty = (count_q == '0);
				end else begin
					ram_we = 1'b1;
					if (ovf) begin
						push             = 1'b1;
						finish           = 1'b1;
						push_desc.len    = LEN_W'(cnt_nx);
						push_desc.reason = REASON_OVERFLOW;
					end else begin
						count_d = cnt_nx;
						run_d   = 1'b1;
						idle_d  = '0;
					end
				end
			end else if (run_q) begin
				if (tmo) begin
					push             = 1'b1;
					finish           = 1'b1;
					push_desc.reason = REASON_TIMEOUT;
				end else begin
					idle_d = idle_nx;
				end
			end
		end
		if (finish) begin
			count_d = '0;
			run_d   = 1'b0;
			idle_d  = '0;
		end
		// A line with bytes hands its bank to the back end; the next line uses the other one.
		bank_d = (finish && !push_desc.empty) ? !bank_q : bank_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RST;
			timeout_q   <= TIMEOUT_RST;
			count_q     <= '0;
			run_q       <= 1'b0;
			idle_q      <= '0;
			bank_q      <= 1'b0;
			outst_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IDX_MAX_CHARS: max_chars_q <= cfg_wdata[3:0];
					CFG_IDX_TIMEOUT:   timeout_q   <= cfg_wdata;
					default: ;
				endcase
			end
			count_q <= count_d;
			run_q   <= run_d;
			idle_q  <= idle_d;
			bank_q  <= bank_d;
			if (push && !line_done) begin
				outst_q <= outst_q + 2'd1;
			end else if (!push && line_done) begin
				outst_q <= outst_q - 2'd1;
			end
		end
	end

	`LRT_ASSERT(a_count_in_store, count_q < CW'(STORE_DEPTH), "stored count reached store depth")
	`LRT_NEVER(a_outst_range, outst_q == 2'd3, "more than two lines outstanding")
	`LRT_NEVER(a_done_without_line, line_done && (outst_q == 2'd0), "line done with none outstanding")
endmodule

// File: rtl/lrt_queue.sv
// Two-entry queue of finished line descriptors between front and back.
`include "assert_macros.svh"
module lrt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lrt_pkg::desc_t push_desc,
	input  logic           pop,
	output logic           head_valid,
	output lrt_pkg::desc_t head_desc
);
	import lrt_pkg::*;

	desc_t      ent_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;

	assign head_valid = (fill_q != 2'd0);
	assign head_desc  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	`LRT_NEVER(a_push_full, push && (fill_q == 2'd2), "push into a full queue")
	`LRT_NEVER(a_pop_empty, pop && (fill_q == 2'd0), "pop from an empty queue")
endmodule

// File: rtl/lrt_back.sv
// Back end: reads a finished line from the store and sends it byte by byte.
`include "assert_macros.svh"
module lrt_back #(
	parameter int STORE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  lrt_pkg::desc_t               head_desc,
	output logic                         pop,
	output logic                         ram_re,
	output logic [$clog2(STORE_DEPTH):0] ram_raddr,
	input  logic [7:0]                   ram_rdata,
	output logic                         line_done,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [7:0]                   m_tdata,
	output logic [2:0]                   m_tuser,
	output logic                         m_tlast
);
	import lrt_pkg::*;

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int AW = $clog2(STORE_DEPTH);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_RUN  = 2'b10
	} back_state_t;

	back_state_t   state_q;
	desc_t         cur_q;
	logic [CW-1:0] idx_q;
	logic          rd_pend_s1;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	reason_t       out_reason_q;
	logic          out_last_q, out_empty_q;
	logic          out_free;

	assign out_free  = !out_valid_q || m_tready;
	assign pop       = (state_q == B_IDLE) && head_valid && out_free;
	assign ram_re    = (state_q == B_RUN) && !rd_pend_s1 && out_free;
	assign ram_raddr = {cur_q.bank, idx_q[AW-1:0]};
	assign line_done = out_valid_q && m_tready && out_last_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_empty_q, out_reason_q};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_desc;
		end
		if (pop && head_desc.empty) begin
			out_byte_q   <= '0;
			out_reason_q <= head_desc.reason;
			out_last_q   <= 1'b1;
			out_empty_q  <= 1'b1;
		end else if (rd_pend_s1) begin
			out_byte_q   <= ram_rdata;
			out_reason_q <= cur_q.reason;
			out_last_q   <= (idx_q == cur_q.len[CW-1:0]);
			out_empty_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= ram_re;
			if ((pop && head_desc.empty) || rd_pend_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop && !head_desc.empty) begin
						idx_q   <= '0;
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					if (ram_re) begin
						idx_q <= idx_q + CW'(1);
					end
					// The byte that arrives with the index at the line length is the last one.
					if (rd_pend_s1 && (idx_q == cur_q.len[CW-1:0])) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`LRT_ASSERT(a_read_in_run, rd_pend_s1 |-> (state_q == B_RUN), "read data outside a line")
	`LRT_NEVER(a_load_over_busy, rd_pend_s1 && out_valid_q, "read data would overwrite a pending result")
endmodule

// File: rtl/line_receiver_with_timeout_unit.sv
// Top level of the line receiver with idle timeout.
//
//  Port group   Direction  Payload
//  s_*          in         tdata[7:0] rx_byte, tuser[0] op (0 byte, 1 tick)
//  m_*          out        tdata[7:0] line_byte, tuser[1:0] end_reason,
//                          tuser[2] is_empty, tlast is_last
//  cfg_*        in         index 0 max_chars, index 1 timeout_limit
//
// The front takes one item per cycle; it holds off input while two finished lines
// are still waiting for or in the output path.
// The back sends a line byte by byte through a registered store read, then the output
// register; each read waits for the one before it to land; an empty line skips the store.
// The line store is two banks of STORE_DEPTH bytes, each padded up to a power of two,
// so a new line fills while the last drains.
// Reset is asynchronous and needs no clearing pass; store entries are always written first.
module line_receiver_with_timeout_unit #(
	parameter int STORE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // rx_byte
	input  logic                           s_tuser,   // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // line_byte
	output logic [2:0]                     m_tuser,   // end_reason[1:0], is_empty
	output logic                           m_tlast,
	input  logic                           cfg_we,
	input  logic [lrt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import lrt_pkg::*;

	localparam int RAW       = $clog2(STORE_DEPTH) + 1;
	localparam int RAM_DEPTH = 2 ** RAW;

	logic           push, pop, head_valid, line_done;
	desc_t          push_desc, head_desc;
	logic           ram_we, ram_re;
	logic [RAW-1:0] ram_waddr, ram_raddr;
	logic [7:0]     ram_wdata, ram_rdata;

	lrt_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.push_desc (push_desc),
		.line_done (line_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	lrt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_desc  (push_desc),
		.pop        (pop),
		.head_valid (head_valid),
		.head_desc  (head_desc)
	);

	lrt_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lrt_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.pop        (pop),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.line_done  (line_done),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);
endmodule
